### rtl/spsf_pkg.sv
// Shared types and constants for the static pixel state machine.
package spsf_pkg;

    localparam int IDX_BITS = 19;
    localparam int CFG_BITS = 16;
    localparam int ST_BITS  = 3;
    localparam int LMS_BITS = 3;

    // Per-pixel state codes
    localparam logic [ST_BITS-1:0] ST_BG     = 3'd0;
    localparam logic [ST_BITS-1:0] ST_MOVING = 3'd1;
    localparam logic [ST_BITS-1:0] ST_STATIC = 3'd2;
    localparam logic [ST_BITS-1:0] ST_UNCOV  = 3'd3;
    localparam logic [ST_BITS-1:0] ST_OCCL   = 3'd4;

    // Foreground patterns as {long, medium, short}
    localparam logic [LMS_BITS-1:0] LMS_NONE = 3'b000;
    localparam logic [LMS_BITS-1:0] LMS_S    = 3'b001;
    localparam logic [LMS_BITS-1:0] LMS_MS   = 3'b011;
    localparam logic [LMS_BITS-1:0] LMS_L    = 3'b100;
    localparam logic [LMS_BITS-1:0] LMS_LM   = 3'b110;
    localparam logic [LMS_BITS-1:0] LMS_ALL  = 3'b111;

    // Register map, index = paddr[3:2]
    localparam int PADDR_BITS = 4;
    localparam logic [1:0] REG_MAX_EV = 2'd0;
    localparam logic [1:0] REG_THRESH = 2'd1;
    localparam logic [1:0] REG_DECAY  = 2'd2;

    localparam logic [CFG_BITS-1:0] MAX_EV_RST = 16'd750;
    localparam logic [CFG_BITS-1:0] THRESH_RST = 16'd600;
    localparam logic [CFG_BITS-1:0] DECAY_RST  = 16'd1;

    typedef struct packed {
        logic [CFG_BITS-1:0] max_evidence;
        logic [CFG_BITS-1:0] static_threshold;
        logic [CFG_BITS-1:0] decay_step;
    } cfg_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic [LMS_BITS-1:0] lms;
    } item_t;

endpackage

### rtl/spsf_if.sv
// Stream interfaces for pixel items in and result items out.
interface spsf_in_if;
    logic                          valid;
    logic                          ready;
    logic [spsf_pkg::IDX_BITS-1:0] pixel_index;
    logic                          long_fg;
    logic                          medium_fg;
    logic                          short_fg;

    modport source (output valid, pixel_index, long_fg, medium_fg, short_fg, input ready);
    modport sink (input valid, pixel_index, long_fg, medium_fg, short_fg, output ready);
endinterface

interface spsf_out_if;
    logic                          valid;
    logic                          ready;
    logic                          static_flag;
    logic [spsf_pkg::ST_BITS-1:0]  pixel_state;
    logic [spsf_pkg::CFG_BITS-1:0] evidence_level;

    modport source (output valid, static_flag, pixel_state, evidence_level, input ready);
    modport sink (input valid, static_flag, pixel_state, evidence_level, output ready);
endinterface

### rtl/spsf_cfg.sv
// APB register block holding the evidence limit, threshold and decay step.
module spsf_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spsf_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output spsf_pkg::cfg_t                    cfg
);

    spsf_pkg::cfg_t cfg_reg;
    spsf_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                spsf_pkg::REG_MAX_EV: cfg_next.max_evidence     = pwdata[15:0];
                spsf_pkg::REG_THRESH: cfg_next.static_threshold = pwdata[15:0];
                spsf_pkg::REG_DECAY:  cfg_next.decay_step       = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            spsf_pkg::REG_MAX_EV: prdata = {16'd0, cfg_reg.max_evidence};
            spsf_pkg::REG_THRESH: prdata = {16'd0, cfg_reg.static_threshold};
            spsf_pkg::REG_DECAY:  prdata = {16'd0, cfg_reg.decay_step};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_evidence     <= spsf_pkg::MAX_EV_RST;
            cfg_reg.static_threshold <= spsf_pkg::THRESH_RST;
            cfg_reg.decay_step       <= spsf_pkg::DECAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/spsf_wrap.sv
// Index wrap: mask if power-of-two or oversized, else a pipelined restoring reduction.
module spsf_wrap #(
    parameter int NUM_PIXELS = 524288
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  spsf_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output spsf_pkg::item_t out_item
);

    localparam int     IN_BITS = spsf_pkg::IDX_BITS;
    localparam longint IDX_MAX = (longint'(1) << IN_BITS) - 1;
    localparam bit     NO_DIV  = (longint'(NUM_PIXELS) > IDX_MAX) ||
                                 ((NUM_PIXELS & (NUM_PIXELS - 1)) == 0);

    generate
        if (NO_DIV)
        begin : g_mask
            localparam logic [IN_BITS-1:0] MASK = (longint'(NUM_PIXELS) > IDX_MAX) ?
                                                  {IN_BITS{1'b1}} : IN_BITS'(NUM_PIXELS - 1);

            always_comb
            begin
                out_item     = in_item;
                out_item.idx = in_item.idx & MASK;
            end

            assign out_valid = in_valid;
            assign in_ready  = out_ready;
        end
        else
        begin : g_reduce
            localparam int STEPS = 4;
            localparam int NSTG  = (IN_BITS + STEPS - 1) / STEPS;

            logic            v_reg [NSTG];
            spsf_pkg::item_t d_reg [NSTG];
            logic            load  [NSTG];

            // Subtract NUM_PIXELS << k where it fits, for this stage's group of k
            function automatic spsf_pkg::item_t reduce_stage(input spsf_pkg::item_t it,
                                                             input int stg);
                spsf_pkg::item_t r;
                int              k;
                longint          d;
                r = it;
                for (int j = 0; j < STEPS; j++)
                begin
                    k = IN_BITS - 1 - stg * STEPS - j;
                    if (k >= 0)
                    begin
                        d = longint'(NUM_PIXELS) << k;
                        if ((d <= IDX_MAX) && (longint'(r.idx) >= d))
                        begin
                            r.idx = r.idx - IN_BITS'(d);
                        end
                    end
                end
                return r;
            endfunction

            always_comb
            begin
                logic take;
                take = 1'b0;
                for (int i = NSTG - 1; i >= 0; i--)
                begin
                    if (i == NSTG - 1)
                    begin
                        take = out_ready;
                    end
                    else
                    begin
                        take = load[i+1];
                    end
                    load[i] = !v_reg[i] || take;
                end
            end

            for (genvar i = 0; i < NSTG; i++)
            begin : g_stg
                logic            src_valid;
                spsf_pkg::item_t src_item;

                if (i == 0)
                begin : g_first
                    assign src_valid = in_valid;
                    assign src_item  = in_item;
                end
                else
                begin : g_next
                    assign src_valid = v_reg[i-1];
                    assign src_item  = d_reg[i-1];
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        v_reg[i] <= 1'b0;
                    end
                    else if (load[i])
                    begin
                        v_reg[i] <= src_valid;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (load[i])
                    begin
                        d_reg[i] <= reduce_stage(src_item, i);
                    end
                end
            end

            assign in_ready  = load[0];
            assign out_valid = v_reg[NSTG-1];
            assign out_item  = d_reg[NSTG-1];
        end
    endgenerate

endmodule

### rtl/spsf_core.sv
// Pixel store with clearing pass, read-modify-write update and output register.
module spsf_core #(
    parameter int NUM_PIXELS    = 524288,
    parameter int EVIDENCE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spsf_pkg::cfg_t                cfg,
    output logic                          clr_busy,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  spsf_pkg::item_t               in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          static_flag,
    output logic [spsf_pkg::ST_BITS-1:0]  pixel_state,
    output logic [spsf_pkg::CFG_BITS-1:0] evidence_level
);

    localparam int EB     = EVIDENCE_BITS;
    localparam int AW     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int WORD_W = spsf_pkg::ST_BITS + EB;
    localparam int CW     = ((EB > spsf_pkg::CFG_BITS) ? EB : spsf_pkg::CFG_BITS) + 1;
    localparam logic [CW-1:0] EV_MASK = CW'((longint'(1) << EB) - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PIXELS - 1);

    typedef enum logic [1:0] {
        CLR_RUN  = 2'b01,
        CLR_DONE = 2'b10
    } clr_state_t;

    logic [WORD_W-1:0] mem [NUM_PIXELS];

    clr_state_t        clr_state_reg, clr_state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;

    logic              s1_valid_reg, s1_valid_next;
    logic [AW-1:0]     s1_addr_reg;
    logic [2:0]        s1_lms_reg;
    logic              s1_fwd_reg, s1_fwd_next;
    logic [WORD_W-1:0] fwd_data_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic [CW-1:0]     lim_reg, lim_next;

    logic              out_valid_reg, out_valid_next;
    logic              flag_reg;
    logic [2:0]        state_reg;
    logic [15:0]       level_reg;

    logic              accept;
    logic              s1_adv;
    logic [AW-1:0]     in_addr;
    logic [WORD_W-1:0] cur;
    logic [2:0]        cur_state;
    logic [CW-1:0]     cur_ev;
    logic [CW-1:0]     decay_w;
    logic [CW-1:0]     stepped;
    logic [CW-1:0]     clamped;
    logic [2:0]        new_state;
    logic [WORD_W-1:0] new_word;
    logic              new_flag;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    function automatic logic [2:0] next_state(input logic [2:0] prev, input logic [2:0] lms);
        logic [2:0] ns;
        ns = prev;
        case (prev)
            spsf_pkg::ST_MOVING:
            begin
                case (lms) inside
                    spsf_pkg::LMS_NONE:                   ns = spsf_pkg::ST_BG;
                    spsf_pkg::LMS_L, spsf_pkg::LMS_LM:    ns = spsf_pkg::ST_STATIC;
                    spsf_pkg::LMS_S, spsf_pkg::LMS_MS:    ns = spsf_pkg::ST_UNCOV;
                    default:                              ns = spsf_pkg::ST_MOVING;
                endcase
            end
            spsf_pkg::ST_STATIC:
            begin
                case (lms) inside
                    spsf_pkg::LMS_ALL:                    ns = spsf_pkg::ST_OCCL;
                    spsf_pkg::LMS_NONE, spsf_pkg::LMS_S,
                    spsf_pkg::LMS_MS:                     ns = spsf_pkg::ST_UNCOV;
                    default:                              ns = spsf_pkg::ST_STATIC;
                endcase
            end
            spsf_pkg::ST_UNCOV:
            begin
                case (lms) inside
                    spsf_pkg::LMS_NONE:                   ns = spsf_pkg::ST_BG;
                    spsf_pkg::LMS_ALL:                    ns = spsf_pkg::ST_MOVING;
                    default:                              ns = spsf_pkg::ST_UNCOV;
                endcase
            end
            spsf_pkg::ST_OCCL:
            begin
                case (lms) inside
                    spsf_pkg::LMS_ALL:                    ns = spsf_pkg::ST_OCCL;
                    spsf_pkg::LMS_NONE, spsf_pkg::LMS_S,
                    spsf_pkg::LMS_MS:                     ns = spsf_pkg::ST_UNCOV;
                    default:                              ns = spsf_pkg::ST_STATIC;
                endcase
            end
            default:
            begin
                // background and unused codes
                if (lms == spsf_pkg::LMS_ALL)
                begin
                    ns = spsf_pkg::ST_MOVING;
                end
                else
                begin
                    ns = spsf_pkg::ST_BG;
                end
            end
        endcase
        return ns;
    endfunction

    // Clearing pass
    always_comb
    begin
        clr_state_next = clr_state_reg;
        clr_addr_next  = clr_addr_reg;
        unique case (clr_state_reg)
            CLR_RUN:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_state_next = CLR_DONE;
                end
            end
            CLR_DONE: clr_state_next = CLR_DONE;
            default:  clr_state_next = CLR_RUN;
        endcase
    end

    assign clr_busy = (clr_state_reg != CLR_DONE);

    // Handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_busy && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;
    assign in_addr  = AW'(in_item.idx);

    // Update of the pixel word
    assign cur       = s1_fwd_reg ? fwd_data_reg : rdata_reg;
    assign cur_state = cur[WORD_W-1 -: spsf_pkg::ST_BITS];
    assign cur_ev    = CW'(cur[EB-1:0]);
    assign decay_w   = CW'(cfg.decay_step);
    assign new_state = next_state(cur_state, s1_lms_reg);

    always_comb
    begin
        if (new_state == spsf_pkg::ST_STATIC)
        begin
            stepped = cur_ev + CW'(1);
        end
        else if (cur_ev < decay_w)
        begin
            stepped = '0;
        end
        else
        begin
            stepped = cur_ev - decay_w;
        end
        clamped = (stepped > lim_reg) ? lim_reg : stepped;
    end

    assign new_word = {new_state, clamped[EB-1:0]};
    assign new_flag = clamped > CW'(cfg.static_threshold);

    always_comb
    begin
        lim_next = (CW'(cfg.max_evidence) > EV_MASK) ? EV_MASK : CW'(cfg.max_evidence);
    end

    // Next-state of the pipeline control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_fwd_next   = s1_fwd_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            // forward the word written in this same cycle
            s1_fwd_next   = s1_adv && (in_addr == s1_addr_reg);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Single write port shared by clearing and write-back
    always_comb
    begin
        mem_we    = clr_busy || s1_adv;
        mem_waddr = clr_busy ? clr_addr_reg : s1_addr_reg;
        mem_wdata = clr_busy ? '0 : new_word;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_state_reg <= CLR_RUN;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_state_reg <= clr_state_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            s1_fwd_reg    <= s1_fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        if (accept)
        begin
            s1_addr_reg <= in_addr;
            s1_lms_reg  <= in_item.lms;
        end
        if (s1_adv)
        begin
            fwd_data_reg <= new_word;
            flag_reg     <= new_flag;
            state_reg    <= new_state;
            level_reg    <= clamped[15:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign static_flag    = flag_reg;
    assign pixel_state    = state_reg;
    assign evidence_level = level_reg;

endmodule

### rtl/static_pixel_state_fsm_top.sv
// Top level of the per-pixel static object state machine.
// Each item carries a pixel address and three foreground bits (long, medium and short
// background models); the block keeps a state code and an evidence count per pixel in
// one single-port-write, registered-read memory and returns one result item per input
// item: the new state, the updated evidence and a flag that the evidence is above the
// threshold. One item is taken per clock when the output side keeps up; the result item
// is presented from the output register after the read stage, plus the index reduction
// pipeline when NUM_PIXELS is not a power of two and below 2^19. A back-to-back update
// of the same pixel is forwarded from the write-back stage. After reset the memory is
// cleared one entry per cycle over all NUM_PIXELS entries, during which no item is
// accepted; register writes are taken at any time.
module static_pixel_state_fsm_top #(
    parameter int NUM_PIXELS    = 524288,
    parameter int EVIDENCE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spsf_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    spsf_in_if.sink                         in_ch,
    spsf_out_if.source                      out_ch
);

    spsf_pkg::cfg_t  cfg;
    spsf_pkg::item_t in_item;
    spsf_pkg::item_t wr_item;
    logic            clr_busy;
    logic            wr_in_valid;
    logic            wr_in_ready;
    logic            wr_out_valid;
    logic            wr_out_ready;

    spsf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_item.idx = in_ch.pixel_index;
    assign in_item.lms = {in_ch.long_fg, in_ch.medium_fg, in_ch.short_fg};

    // hold off items while the store is being cleared
    assign wr_in_valid = in_ch.valid & ~clr_busy;
    assign in_ch.ready = wr_in_ready & ~clr_busy;

    spsf_wrap #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wr_in_valid),
        .in_ready  (wr_in_ready),
        .in_item   (in_item),
        .out_valid (wr_out_valid),
        .out_ready (wr_out_ready),
        .out_item  (wr_item)
    );

    spsf_core #(
        .NUM_PIXELS    (NUM_PIXELS),
        .EVIDENCE_BITS (EVIDENCE_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .clr_busy       (clr_busy),
        .in_valid       (wr_out_valid),
        .in_ready       (wr_out_ready),
        .in_item        (wr_item),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .static_flag    (out_ch.static_flag),
        .pixel_state    (out_ch.pixel_state),
        .evidence_level (out_ch.evidence_level)
    );

endmodule

### tb/static_pixel_state_fsm_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the static pixel state machine: APB setup, per-pixel prediction, random traffic.
module static_pixel_state_fsm_top_tb;

    localparam int NUM_PIXELS     = 524288;
    localparam int WATCHDOG_LIMIT = 1600000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOT_COUNT      = 6;
    localparam int LB             = spsf_pkg::LMS_BITS;
    localparam int SB             = spsf_pkg::ST_BITS;
    localparam int CB             = spsf_pkg::CFG_BITS;
    localparam int IB             = spsf_pkg::IDX_BITS;

    // Foreground patterns that the package leaves unnamed
    localparam logic [LB-1:0] LMS_M  = 3'b010;
    localparam logic [LB-1:0] LMS_LS = 3'b101;

    // Directed walks through the transition table, first pattern in the top bits
    localparam int WALK_A_LEN = 18;
    localparam logic [WALK_A_LEN*LB-1:0] WALK_A = {
        spsf_pkg::LMS_NONE, spsf_pkg::LMS_ALL, spsf_pkg::LMS_L, spsf_pkg::LMS_LM,
        spsf_pkg::LMS_ALL, spsf_pkg::LMS_ALL, LMS_M, spsf_pkg::LMS_S, LMS_LS,
        spsf_pkg::LMS_ALL, spsf_pkg::LMS_MS, spsf_pkg::LMS_NONE, spsf_pkg::LMS_ALL,
        spsf_pkg::LMS_NONE, spsf_pkg::LMS_ALL, spsf_pkg::LMS_LM, spsf_pkg::LMS_ALL,
        spsf_pkg::LMS_MS
    };
    localparam int WALK_B_LEN = 7;
    localparam logic [WALK_B_LEN*LB-1:0] WALK_B = {
        spsf_pkg::LMS_ALL, LMS_M, LMS_LS, spsf_pkg::LMS_S, spsf_pkg::LMS_ALL,
        spsf_pkg::LMS_LM, spsf_pkg::LMS_NONE
    };

    typedef struct packed {
        logic          static_flag;
        logic [SB-1:0] pixel_state;
        logic [CB-1:0] evidence_level;
    } pixel_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [spsf_pkg::PADDR_BITS-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    spsf_in_if  in_ch ();
    spsf_out_if out_ch ();

    static_pixel_state_fsm_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Predicted per-pixel stores; a missing entry reads as cleared
    logic [SB-1:0] pixel_state_mem [int unsigned];
    logic [CB-1:0] evidence_mem [int unsigned];
    logic [CB-1:0] max_evidence_cfg;
    logic [CB-1:0] threshold_cfg;
    logic [CB-1:0] decay_cfg;

    pixel_result_t pending_results [$];
    logic [IB-1:0] hot_pixels [HOT_COUNT];
    int            mismatch_count;
    int            rx_stall_left;
    int            idle_cycles;
    bit            tx_quiet;
    bit            rx_quiet;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void flag_mismatch(input string msg);
        if (mismatch_count < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [SB-1:0] stored_state(input int unsigned key);
        return pixel_state_mem.exists(key) ? pixel_state_mem[key] : spsf_pkg::ST_BG;
    endfunction

    function automatic logic [SB-1:0] next_pixel_state(input logic [SB-1:0] prev,
                                                      input logic [LB-1:0] lms);
        logic uncover;
        uncover = (lms == spsf_pkg::LMS_NONE) || (lms == spsf_pkg::LMS_S) ||
                  (lms == spsf_pkg::LMS_MS);
        case (prev)
            spsf_pkg::ST_MOVING:
                if (lms == spsf_pkg::LMS_NONE)
                    return spsf_pkg::ST_BG;
                else if (lms == spsf_pkg::LMS_L || lms == spsf_pkg::LMS_LM)
                    return spsf_pkg::ST_STATIC;
                else if (lms == spsf_pkg::LMS_S || lms == spsf_pkg::LMS_MS)
                    return spsf_pkg::ST_UNCOV;
                else
                    return spsf_pkg::ST_MOVING;
            spsf_pkg::ST_STATIC:
                if (lms == spsf_pkg::LMS_ALL)  return spsf_pkg::ST_OCCL;
                else if (uncover)              return spsf_pkg::ST_UNCOV;
                else                           return spsf_pkg::ST_STATIC;
            spsf_pkg::ST_UNCOV:
                if (lms == spsf_pkg::LMS_NONE)      return spsf_pkg::ST_BG;
                else if (lms == spsf_pkg::LMS_ALL)  return spsf_pkg::ST_MOVING;
                else                                return spsf_pkg::ST_UNCOV;
            spsf_pkg::ST_OCCL:
                if (lms == spsf_pkg::LMS_ALL)  return spsf_pkg::ST_OCCL;
                else if (uncover)              return spsf_pkg::ST_UNCOV;
                else                           return spsf_pkg::ST_STATIC;
            default:
                return (lms == spsf_pkg::LMS_ALL) ? spsf_pkg::ST_MOVING : spsf_pkg::ST_BG;
        endcase
    endfunction

    function automatic pixel_result_t predict_pixel_update(input logic [IB-1:0] idx,
                                                           input logic [LB-1:0] lms);
        int unsigned   key;
        int unsigned   level;
        logic [SB-1:0] nxt;
        pixel_result_t res;
        key   = idx % NUM_PIXELS;
        level = evidence_mem.exists(key) ? 32'(evidence_mem[key]) : 32'd0;
        nxt   = next_pixel_state(stored_state(key), lms);
        if (nxt == spsf_pkg::ST_STATIC)
            level = level + 32'd1;
        else if (level < 32'(decay_cfg))
            level = 32'd0;
        else
            level = level - 32'(decay_cfg);
        if (level > 32'(max_evidence_cfg))
            level = 32'(max_evidence_cfg);
        pixel_state_mem[key] = nxt;
        evidence_mem[key]    = level[CB-1:0];
        res.static_flag      = (level > 32'(threshold_cfg));
        res.pixel_state      = nxt;
        res.evidence_level   = level[CB-1:0];
        return res;
    endfunction

    // Mostly push a pixel toward static and keep it there, with plain noise mixed in
    function automatic logic [LB-1:0] steer_toward_static(input logic [SB-1:0] prev);
        case (prev)
            spsf_pkg::ST_BG, spsf_pkg::ST_UNCOV: return spsf_pkg::LMS_ALL;
            spsf_pkg::ST_MOVING:
                return $urandom_range(0, 1) ? spsf_pkg::LMS_L : spsf_pkg::LMS_LM;
            default:
                case ($urandom_range(0, 3))
                    0:       return LMS_M;
                    1:       return spsf_pkg::LMS_L;
                    2:       return LMS_LS;
                    default: return spsf_pkg::LMS_LM;
                endcase
        endcase
    endfunction

    task automatic send_pixel(input logic [IB-1:0] idx, input logic [LB-1:0] lms);
        int gap;
        gap = pick_gap(tx_quiet);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.pixel_index <= idx;
        in_ch.long_fg     <= lms[2];
        in_ch.medium_fg   <= lms[1];
        in_ch.short_fg    <= lms[0];
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.push_back(predict_pixel_update(idx, lms));
    endtask

    // Hold off input until every pending result is back, then let the pipe settle
    task automatic wait_for_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [1:0] reg_code,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_code, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic [1:0] reg_code, input logic [CB-1:0] want);
        logic [31:0] rdata;
        apb_transfer(1'b0, reg_code, 32'd0, rdata);
        if (rdata !== {16'd0, want})
            flag_mismatch($sformatf("register %0d read: want %0d, got %0h", reg_code, want,
                                    rdata));
    endtask

    task automatic program_register(input logic [1:0] reg_code, input logic [CB-1:0] value);
        logic [31:0] unused;
        wait_for_results();
        apb_transfer(1'b1, reg_code, {16'd0, value}, unused);
        case (reg_code)
            spsf_pkg::REG_MAX_EV: max_evidence_cfg = value;
            spsf_pkg::REG_THRESH: threshold_cfg    = value;
            default:              decay_cfg        = value;
        endcase
        check_register(reg_code, value);
    endtask

    task automatic program_all(input logic [CB-1:0] max_ev, input logic [CB-1:0] thresh,
                               input logic [CB-1:0] decay);
        program_register(spsf_pkg::REG_MAX_EV, max_ev);
        program_register(spsf_pkg::REG_THRESH, thresh);
        program_register(spsf_pkg::REG_DECAY, decay);
    endtask

    task automatic run_random_items(input int count, input int wide_pct, input int drain_every);
        int            i;
        logic [IB-1:0] idx;
        logic [LB-1:0] lms;
        for (i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < wide_pct)
            begin
                idx = IB'($urandom);
                lms = LB'($urandom);
            end
            else
            begin
                idx = hot_pixels[$urandom_range(0, HOT_COUNT-1)];
                if ($urandom_range(0, 99) < 75)
                    lms = steer_toward_static(stored_state(32'(idx)));
                else
                    lms = LB'($urandom);
            end
            send_pixel(idx, lms);
            if (drain_every != 0 && i % drain_every == drain_every - 1)
                wait_for_results();
        end
    endtask

    task automatic test_register_reset_values();
        check_register(spsf_pkg::REG_MAX_EV, spsf_pkg::MAX_EV_RST);
        check_register(spsf_pkg::REG_THRESH, spsf_pkg::THRESH_RST);
        check_register(spsf_pkg::REG_DECAY, spsf_pkg::DECAY_RST);
    endtask

    task automatic test_state_transitions();
        int i;
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (i = 0; i < WALK_A_LEN; i++)
            send_pixel('0, WALK_A[(WALK_A_LEN-1-i)*LB +: LB]);
        for (i = 0; i < WALK_B_LEN; i++)
            send_pixel('1, WALK_B[(WALK_B_LEN-1-i)*LB +: LB]);
        wait_for_results();
    endtask

    task automatic test_default_walk();
        run_random_items(250, 10, 0);
    endtask

    task automatic test_small_clamp();
        program_all(16'd12, 16'd9, 16'd1);
        run_random_items(300, 10, 0);
    endtask

    // Lower the clamp under the evidence already built up
    task automatic test_lowered_clamp();
        program_all(16'd4, 16'd0, 16'd0);
        run_random_items(180, 10, 0);
    endtask

    task automatic test_register_extremes();
        program_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_items(120, 15, 16);
        program_all(16'd0, 16'd0, 16'd2);
        run_random_items(100, 15, 0);
    endtask

    task automatic test_mid_settings();
        program_all(16'd10, 16'd7, 16'd3);
        run_random_items(150, 10, 0);
    endtask

    // Sink side: random stalls on ready
    always @(negedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_stall_left = pick_gap(rx_quiet);
        end
    end

    always @(posedge clk)
    begin
        pixel_result_t want;
        pixel_result_t seen;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
        begin
            seen = '{out_ch.static_flag, out_ch.pixel_state, out_ch.evidence_level};
            if (pending_results.size() == 0)
                flag_mismatch($sformatf({"result item with none pending: ",
                                         "flag=%0b state=%0d level=%0d"},
                                        seen.static_flag, seen.pixel_state,
                                        seen.evidence_level));
            else
            begin
                want = pending_results.pop_front();
                if (want.static_flag !== seen.static_flag
                    || want.pixel_state !== seen.pixel_state
                    || want.evidence_level !== seen.evidence_level)
                    flag_mismatch($sformatf({"want flag=%0b state=%0d level=%0d, ",
                                             "got flag=%0b state=%0d level=%0d"},
                                            want.static_flag, want.pixel_state,
                                            want.evidence_level, seen.static_flag,
                                            seen.pixel_state, seen.evidence_level));
            end
        end
    end

    // Watchdog: the clearing pass after reset is the longest legal quiet stretch
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("static_pixel_state_fsm_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.pixel_index = '0;
        in_ch.long_fg     = 1'b0;
        in_ch.medium_fg   = 1'b0;
        in_ch.short_fg    = 1'b0;
        out_ch.ready      = 1'b0;
        mismatch_count    = 0;
        rx_stall_left     = 0;
        idle_cycles       = 0;
        tx_quiet          = 1'b0;
        rx_quiet          = 1'b0;
        max_evidence_cfg  = spsf_pkg::MAX_EV_RST;
        threshold_cfg     = spsf_pkg::THRESH_RST;
        decay_cfg         = spsf_pkg::DECAY_RST;
        hot_pixels[0]     = '0;
        hot_pixels[1]     = '1;
        for (i = 2; i < HOT_COUNT; i++)
            hot_pixels[i] = IB'($urandom);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset_values();
        test_state_transitions();
        test_default_walk();
        test_small_clamp();
        test_lowered_clamp();
        test_register_extremes();
        test_mid_settings();
        wait_for_results();

        if (mismatch_count == 0)
            $display("static_pixel_state_fsm_top_tb: PASS");
        else
            $display("static_pixel_state_fsm_top_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/spsf_pkg.sv
rtl/spsf_if.sv
rtl/spsf_cfg.sv
rtl/spsf_wrap.sv
rtl/spsf_core.sv
rtl/static_pixel_state_fsm_top.sv
tb/static_pixel_state_fsm_top_tb.sv
